>>> design/spss_pkg.sv
package spss_pkg;

  localparam int unsigned SEED_WORDS = 4;

  // Input function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // SHA-256 round constants
  function automatic logic [31:0] sha_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  localparam logic [255:0] SHA_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

>>> design/spss_sha.sv
// One SHA-256 compression of seed || counter, one round per cycle.
module spss_sha (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] seed,     // seed byte 0 in bits 7:0
  input  logic [31:0]  counter,
  output logic         done,
  output logic [63:0]  word      // first 8 digest bytes, little endian
);
  import spss_pkg::*;

  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [5:0]  rnd;
  logic        busy;

  logic [31:0] s0, s1, wn, t1, t2, bs0, bs1, ch, mj;
  logic [31:0] h0, h1;

  always_comb begin
    s0  = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1  = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wn  = w[0] + s0 + w[9] + s1;
    bs1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch  = (e & f) ^ (~e & g);
    bs0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    mj  = (a & b) ^ (a & c) ^ (b & c);
    t1  = h + bs1 + ch + sha_k(rnd) + w[0];
    t2  = bs0 + mj;
    h0  = SHA_INIT[255:224] + a;
    h1  = SHA_INIT[223:192] + b;
    word = {bswap(h1), bswap(h0)};
  end

  // round control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= !start && busy && (rnd == 6'd63);
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // message schedule window and working variables
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        w[i] <= bswap(seed[32*i +: 32]);
      end
      w[8]  <= bswap(counter);
      w[9]  <= 32'h8000_0000;
      for (int i = 10; i < 15; i++) begin
        w[i] <= '0;
      end
      w[15] <= 32'h0000_0120;
      {a, b, c, d, e, f, g, h} <= SHA_INIT;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= wn;
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
  end
endmodule

>>> design/spss_mod.sv
// 64-bit by 7-bit restoring remainder, one dividend bit per cycle.
module spss_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [6:0]  divisor,
  output logic        done,
  output logic [6:0]  rem
);
  logic [63:0] shreg;
  logic [6:0]  cnt;
  logic        busy;
  logic [7:0]  trial;

  assign trial = {rem, shreg[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 7'd63);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[62:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= 7'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[6:0];
      end
    end
  end
endmodule

>>> design/seeded_partial_shuffle_sampler_unit.sv
// Channel | Dir | tdata (low bit up)                                | tuser / tlast
// s_axis  | in  | word_select[1:0] word_value[65:2] pool_size[72:66] | tuser=func
//         |     | winner_count[83:73], zero fill to 88 bits          |
// m_axis  | out | winner_position[5:0] winner_rank[11:6], 16 bits    | tlast=last
//
// A seed load or an empty draw is handled in S_IDLE. A draw with k < n fills the
// pool, then per winner runs SHA start, 64 rounds, 64 remainder steps, read and
// swap; SHA core and remainder unit set the rate. Each output beat passes through
// read, present and accept, plus any m_axis_tready stall.
// Synchronous reset clears the seed and control.
// The output stalls on m_axis_tready; s_axis_tready stays low until the draw ends.
module seeded_partial_shuffle_sampler_unit #(
  parameter int unsigned MAX_POOL = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // word_select, word_value, pool_size, winner_count
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // winner_position, winner_rank
  output logic        m_axis_tlast    // last
);
  import spss_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POOL);
  localparam logic [6:0] MAXP = 7'(MAX_POOL);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001, S_FILL = 7'b0000010, S_HASH = 7'b0000100,
    S_READ  = 7'b0001000, S_SWAP = 7'b0010000, S_FETCH = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state;
  logic [63:0] seed_store [SEED_WORDS];
  logic [AW-1:0] pool_order [MAX_POOL];
  logic [AW-1:0] rd_a, rd_b;
  logic [6:0] n, cnt, i;
  logic [6:0] draw_step;
  logic       shuffle;
  logic       shuffle_wait;

  logic        sha_start, sha_done, mod_start, mod_done;
  logic [63:0] sha_word;
  logic [6:0]  rem;
  logic [6:0]  n_in;
  logic [10:0] k_in;
  logic        acc;

  assign s_axis_tready = (state == S_IDLE);
  assign acc  = s_axis_tvalid && s_axis_tready;
  assign n_in = (s_axis_tdata[72:66] > MAXP) ? MAXP : s_axis_tdata[72:66];
  assign k_in = s_axis_tdata[83:73];
  assign sha_start = (state == S_HASH) && !shuffle_wait;
  assign mod_start = sha_done;

  spss_sha u_sha (
    .clk(clk), .rst(rst), .start(sha_start),
    .seed({seed_store[3], seed_store[2], seed_store[1], seed_store[0]}),
    .counter({25'd0, i}), .done(sha_done), .word(sha_word)
  );

  spss_mod u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(sha_word),
    .divisor(7'(n - i)), .done(mod_done), .rem(rem)
  );

  logic [6:0] idx;
  assign idx = 7'(rem + i);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int j = 0; j < SEED_WORDS; j++) begin
        seed_store[j] <= '0;
      end
      draw_step <= '0;
      shuffle_wait <= 1'b0;
      i <= '0; n <= '0; cnt <= '0; shuffle <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (s_axis_tuser == FUNC_LOAD) begin
              seed_store[s_axis_tdata[1:0]] <= s_axis_tdata[65:2];
            end else begin
              n <= n_in;
              i <= '0;
              if (n_in == 7'd0 || k_in == 11'd0) begin
                draw_step <= '0;
              end else begin
                shuffle <= ({4'd0, n_in} > k_in);
                cnt <= ({4'd0, n_in} > k_in) ? 7'(k_in) : n_in;
                draw_step <= ({4'd0, n_in} > k_in) ? 7'(k_in) : n_in;
                state <= S_FILL;
              end
            end
          end
        end
        S_FILL: begin
          pool_order[i[AW-1:0]] <= i[AW-1:0];
          if (i == n - 7'd1) begin
            i <= '0;
            state <= shuffle ? S_HASH : S_FETCH;
            shuffle_wait <= 1'b0;
          end else begin
            i <= i + 7'd1;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            shuffle_wait <= 1'b0;
            state <= S_READ;
          end else begin
            shuffle_wait <= 1'b1;
          end
        end
        // registered read of both swap entries
        S_READ: begin
          rd_a <= pool_order[i[AW-1:0]];
          rd_b <= pool_order[idx[AW-1:0]];
          state <= S_SWAP;
        end
        S_SWAP: begin
          pool_order[i[AW-1:0]] <= rd_b;
          if (idx != i) begin
            pool_order[idx[AW-1:0]] <= rd_a;
          end
          if (i == cnt - 7'd1) begin
            i <= '0;
            state <= S_FETCH;
          end else begin
            i <= i + 7'd1;
            state <= S_HASH;
          end
        end
        // registered read of the next winner
        S_FETCH: begin
          rd_a <= pool_order[i[AW-1:0]];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'd0, i[5:0], 6'(rd_a)};
            m_axis_tlast  <= (i == cnt - 7'd1);
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) begin
              state <= S_IDLE;
            end else begin
              i <= i + 7'd1;
              state <= S_FETCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/spss_checker.sv
module spss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  // no new input while a result is shown
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");

  // ranks count up by one within a draw; the next beat shows after fetch and emit
  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
    !m_axis_tvalid ##1 !m_axis_tvalid ##1
    (m_axis_tvalid && m_axis_tdata[11:6] == 6'($past(m_axis_tdata[11:6], 3) + 6'd1)))
    else $error("rank skipped");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed under stall");

  // after the last beat the block returns to taking input
  a_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("no return to idle");
endmodule

bind seeded_partial_shuffle_sampler_unit spss_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

>>> sim/spss_checker.sv
`timescale 1ns / 1ps
module spss_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending_winners
);
  import spss_pkg::*;

  typedef struct packed {
    logic [5:0] position;
    logic [5:0] rank;
    logic       last;
  } winner_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic [63:0] seed_copy [4];
  winner_t     winner_queue [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // First eight digest bytes, little endian, of hash(seed || counter)
  function automatic logic [63:0] draw_random(input logic [31:0] counter);
    logic [7:0]  blk [64];
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, h0, h1;
    logic [63:0] r;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 32; i++) blk[i] = seed_copy[i / 8][8 * (i % 8) +: 8];
    for (int i = 0; i < 4; i++) blk[32 + i] = counter[8 * i +: 8];
    blk[36] = 8'h80;
    blk[62] = 8'h01;
    blk[63] = 8'h20;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i - 15], 7) ^ ror(w[i - 15], 18) ^ (w[i - 15] >> 3);
      s1 = ror(w[i - 2], 17) ^ ror(w[i - 2], 19) ^ (w[i - 2] >> 10);
      w[i] = w[i - 16] + s0 + w[i - 7] + s1;
    end
    a = 32'h6a09e667; b = 32'hbb67ae85; c = 32'h3c6ef372; d = 32'ha54ff53a;
    e = 32'h510e527f; f = 32'h9b05688c; g = 32'h1f83d9ab; h = 32'h5be0cd19;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    h0 = 32'h6a09e667 + a;
    h1 = 32'hbb67ae85 + b;
    r = {h1[7:0], h1[15:8], h1[23:16], h1[31:24], h0[7:0], h0[15:8], h0[23:16], h0[31:24]};
    return r;
  endfunction

  // Predict the winners of one start beat
  task automatic predict_draw(input logic [6:0] size_in, input logic [10:0] count_in);
    int unsigned n, k, cnt, idx;
    logic [5:0]  pool [64];
    logic [5:0]  tmp;
    logic [63:0] r;
    winner_t     wn;
    n = (size_in > 64) ? 64 : size_in;
    k = count_in;
    for (int i = 0; i < 64; i++) pool[i] = i[5:0];
    if (n == 0 || k == 0) return;
    if (k >= n) cnt = n;
    else begin
      cnt = k;
      for (int i = 0; i < k; i++) begin
        r = draw_random(i);
        idx = 32'(r % 64'(n - i)) + i;
        tmp = pool[i]; pool[i] = pool[idx]; pool[idx] = tmp;
      end
    end
    for (int i = 0; i < cnt; i++) begin
      wn.position = pool[i];
      wn.rank = i[5:0];
      wn.last = (i + 1 == cnt);
      winner_queue = {winner_queue, wn};
    end
  endtask

  assign pending_winners = winner_queue.size();

  // Input beats update the seed copy or queue predictions
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) seed_copy[i] = '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser == FUNC_LOAD) seed_copy[s_axis_tdata[1:0]] = s_axis_tdata[65:2];
      else predict_draw(s_axis_tdata[72:66], s_axis_tdata[83:73]);
    end
  end

  // Output beats are compared with the oldest prediction
  initial fail_count = 0;
  always @(posedge clk) begin
    winner_t ex;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (winner_queue.size() == 0) begin
        $error("unexpected output beat %h", m_axis_tdata);
        fail_count++;
      end else begin
        ex = winner_queue.pop_front();
        if (m_axis_tdata[5:0] !== ex.position) begin
          $error("winner_position exp %0d got %0d", ex.position, m_axis_tdata[5:0]);
          fail_count++;
        end
        if (m_axis_tdata[11:6] !== ex.rank) begin
          $error("winner_rank exp %0d got %0d", ex.rank, m_axis_tdata[11:6]);
          fail_count++;
        end
        if (m_axis_tlast !== ex.last) begin
          $error("last exp %0d got %0d", ex.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import spss_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;  // word_select, word_value, pool_size, winner_count
  logic        s_axis_tuser = 1'b0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // winner_position, winner_rank
  logic        m_axis_tlast;  // last
  int          fail_count;
  int          pending_winners;
  int          send_idle_pct = 34;
  int          recv_idle_pct = 56;
  bit          hold_off = 1'b0;

  seeded_partial_shuffle_sampler_unit dut (.*);
  spss_monitor checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one beat, with a random idle gap before it
  task automatic send_beat(input logic fn, input logic [1:0] sel, input logic [63:0] val,
                           input logic [6:0] size_in, input logic [10:0] count_in);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {4'b0, count_in, size_in, val, sel};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic random_seed();
    for (int j = 0; j < 4; j++)
      send_beat(FUNC_LOAD, 2'(j), {$urandom, $urandom}, 7'($urandom), 11'($urandom));
  endtask

  // Mostly small pools and counts, occasionally the extremes
  task automatic random_draw();
    logic [6:0]  n;
    logic [10:0] k;
    n = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
    case ($urandom_range(5))
      0: k = 11'($urandom);
      1: k = 11'(n);
      default: k = 11'($urandom_range(n > 0 ? n : 1));
    endcase
    send_beat(FUNC_START, 2'($urandom), {$urandom, $urandom}, n, k);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: zero seed, empty draws, all-winners, saturation, field extremes
    send_beat(FUNC_START, 2'd3, '1, 7'd5, 11'd3);
    send_beat(FUNC_START, 2'd0, '0, 7'd0, 11'd5);
    send_beat(FUNC_START, 2'd0, '0, 7'd5, 11'd0);
    send_beat(FUNC_START, 2'd0, '0, 7'd6, 11'd6);
    send_beat(FUNC_START, 2'd0, '0, 7'd4, 11'd2047);
    send_beat(FUNC_START, 2'd0, '0, 7'd127, 11'd2047);
    send_beat(FUNC_LOAD, 2'd0, '1, 7'd127, 11'd2047);
    send_beat(FUNC_LOAD, 2'd1, 64'h0123456789abcdef, 7'd0, 11'd0);
    send_beat(FUNC_LOAD, 2'd2, '0, 7'd0, 11'd0);
    send_beat(FUNC_LOAD, 2'd3, 64'hfedcba9876543210, 7'd1, 11'd1);
    send_beat(FUNC_START, 2'd1, '0, 7'd2, 11'd1);
    send_beat(FUNC_START, 2'd0, '1, 7'd64, 11'd63);
    send_beat(FUNC_START, 2'd0, '0, 7'd1, 11'd1);
    send_beat(FUNC_START, 2'd0, '0, 7'd100, 11'd2);
    // Long receiver hold-off while starts keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (3) send_beat(FUNC_START, 2'd0, '0, 7'd8, 11'd8);
      end
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    // Random phases with different idling
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 34 : 0;
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(3) == 0) random_seed();
        else if ($urandom_range(4) == 0)
          send_beat(FUNC_LOAD, 2'($urandom), {$urandom, $urandom}, 7'($urandom),
                    11'($urandom));
        random_draw();
        random_draw();
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_winners != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
